### rtl/size_class_free_list_allocator_assert.svh
// Assertion macros for the size class free list allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SCFA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
`define SCFA_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `SCFA_ASSERT(label, clk, rstn, !(cond), msg)
`else
`define SCFA_ASSERT(label, clk, rstn, prop, msg)
`define SCFA_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

### rtl/scfla_pkg.sv
// Package for the size class free list allocator: sizes, codes and state type.
// No dependencies.
`default_nettype none

package scfla_pkg;

    localparam int NUM_CLASSES = 512;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int PAGE_UNITS  = 32768;
    localparam int PAGE_W      = $clog2(PAGE_UNITS);
    localparam int PAGE_COUNT  = 4;

    localparam int BYTES_W   = 32;
    localparam int ADDR_W    = 20;
    localparam int UNIT_W    = 18;
    localparam int HDR_W     = 17;
    localparam int HDR_DEPTH = 1 << HDR_W;
    localparam int WIDE_W    = UNIT_W + 2;
    localparam int USER_W    = 3;

    localparam int ARENA_UNITS  = PAGE_UNITS * PAGE_COUNT;
    localparam int MAX_HDR_UNIT = (1 << ADDR_W) / 8 - 2;

    localparam int S_TDATA_W = ((BYTES_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + UNIT_W + 7) / 8) * 8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_MEMORY = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_AHEAD,
        S_APOP,
        S_FHDR,
        S_FPUSH
    } state_t;

endpackage

`default_nettype wire

### rtl/size_class_free_list_allocator.sv
// Size class free list allocator: list head memory, header memory, bump pointer.
// Depends on scfla_pkg and size_class_free_list_allocator_assert.svh.
//
// Channel  Dir  Payload
// s_       in   tdata: request_bytes, free_address; tuser: op
// m_       out  tdata: block_address, usage_units; tuser: status, reused
//
// Too large, free of zero and address checks are answered from S_IDLE; a bump alloc
// answers from S_AHEAD once the list head reads empty. Pop and free wait on two dependent
// reads of the synchronous list head and header memories. One item is in flight at a time.
// After reset a pass clears the 512 list heads, one a cycle, before s_tready rises.
// A result waits in the output register; the next item is taken once it transfers.
`default_nettype none

`include "size_class_free_list_allocator_assert.svh"

module size_class_free_list_allocator
    import scfla_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // request_bytes, free_address, zero fill
    input  wire logic                 s_tuser,   // op
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // block_address, usage_units, zero fill
    output logic [USER_W-1:0]         m_tuser    // status, reused
);

    state_t              state_reg, state_next;
    logic [CLASS_W-1:0]  clr_reg, clr_next;
    logic [CLASS_W-1:0]  cls_reg, cls_next;
    logic [HDR_W-1:0]    unit_reg, unit_next;
    logic [UNIT_W-1:0]   bump_reg, bump_next;
    logic [UNIT_W-1:0]   usage_reg, usage_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_status_reg, out_status_next;
    logic                out_reused_reg, out_reused_next;

    logic [UNIT_W-1:0]   head_mem [NUM_CLASSES];
    logic [HDR_W-1:0]    hdr_mem [HDR_DEPTH];
    logic [UNIT_W-1:0]   head_rdata_reg;
    logic [HDR_W-1:0]    hdr_rdata_reg;
    logic [CLASS_W-1:0]  head_raddr, head_waddr;
    logic [UNIT_W-1:0]   head_wdata;
    logic                head_we;
    logic [HDR_W-1:0]    hdr_raddr, hdr_waddr, hdr_wdata;
    logic                hdr_we;

    op_t                 in_op;
    logic [BYTES_W-1:0]  in_bytes;
    logic [ADDR_W-1:0]   in_faddr;
    logic                accept;
    logic [CLASS_W:0]    cls_sum;
    logic                too_large;
    logic [HDR_W-1:0]    free_unit;
    logic                free_oob;

    logic [UNIT_W-1:0]   page;
    logic [WIDE_W-1:0]   page_end, avail, need, start;
    logic                no_fit, last_page, no_room;

    assign in_op    = op_t'(s_tuser);
    assign in_bytes = s_tdata[BYTES_W-1:0];
    assign in_faddr = s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
    assign accept   = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({usage_reg, out_addr_reg});
    assign m_tuser  = {out_reused_reg, out_status_reg};

    assign cls_sum   = {1'b0, in_bytes[CLASS_W+2:3]} + (CLASS_W+1)'(|in_bytes[2:0]);
    assign too_large = (|in_bytes[BYTES_W-1:CLASS_W+3]) || cls_sum[CLASS_W];
    assign free_unit = in_faddr[ADDR_W-1:3] - HDR_W'(1);
    assign free_oob  = {1'b0, free_unit} >= bump_reg;

    assign page      = bump_reg >> PAGE_W;
    assign page_end  = (WIDE_W'(page) + WIDE_W'(1)) << PAGE_W;
    assign avail     = (page < UNIT_W'(PAGE_COUNT)) ? page_end - WIDE_W'(bump_reg) : '0;
    assign need      = WIDE_W'(cls_reg) + WIDE_W'(1);
    assign no_fit    = need > avail;
    assign last_page = (WIDE_W'(page) + WIDE_W'(1)) >= WIDE_W'(PAGE_COUNT);
    assign start     = no_fit ? page_end : WIDE_W'(bump_reg);
    assign no_room   = (no_fit && (last_page || need > WIDE_W'(PAGE_UNITS)))
                       || (start > WIDE_W'(MAX_HDR_UNIT));

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata_reg <= head_mem[head_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        hdr_rdata_reg <= hdr_mem[hdr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            bump_reg      <= '0;
            usage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bump_reg      <= bump_next;
            usage_reg     <= usage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg        <= cls_next;
        unit_reg       <= unit_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_reused_reg <= out_reused_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cls_next        = cls_reg;
        unit_next       = unit_reg;
        bump_next       = bump_reg;
        usage_next      = usage_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_reused_next = out_reused_reg;
        head_raddr      = cls_sum[CLASS_W-1:0];
        head_we         = 1'b0;
        head_waddr      = cls_reg;
        head_wdata      = '0;
        hdr_raddr       = free_unit;
        hdr_we          = 1'b0;
        hdr_waddr       = unit_reg;
        hdr_wdata       = '0;

        case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + CLASS_W'(1);
                if (clr_reg == CLASS_W'(NUM_CLASSES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    out_addr_next   = '0;
                    out_reused_next = 1'b0;
                    out_status_next = ST_OK;
                    unit_next       = free_unit;
                    cls_next        = cls_sum[CLASS_W-1:0];
                    if (in_op == OP_ALLOC) begin
                        if (too_large) begin
                            out_status_next = ST_TOO_LARGE;
                            out_valid_next  = 1'b1;
                        end else begin
                            state_next = S_AHEAD;
                        end
                    end else if (in_faddr == '0) begin
                        out_valid_next = 1'b1;
                    end else if (in_faddr[2:0] != 3'b000 || free_oob) begin
                        out_status_next = ST_BAD_FREE;
                        out_valid_next  = 1'b1;
                    end else begin
                        state_next = S_FHDR;
                    end
                end
            end
            S_AHEAD: begin
                hdr_raddr = head_rdata_reg[HDR_W-1:0] - HDR_W'(1);
                unit_next = head_rdata_reg[HDR_W-1:0] - HDR_W'(1);
                if (head_rdata_reg != '0) begin
                    state_next = S_APOP;
                end else begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (no_room) begin
                        out_status_next = ST_NO_MEMORY;
                    end else begin
                        hdr_we        = 1'b1;
                        hdr_waddr     = start[HDR_W-1:0];
                        hdr_wdata     = HDR_W'(cls_reg);
                        bump_next     = UNIT_W'(start + need);
                        usage_next    = usage_reg + UNIT_W'(cls_reg);
                        out_addr_next = ADDR_W'({start + WIDE_W'(1), 3'b000});
                    end
                end
            end
            S_APOP: begin
                head_we         = 1'b1;
                head_wdata      = UNIT_W'(hdr_rdata_reg);
                hdr_we          = 1'b1;
                hdr_wdata       = HDR_W'(cls_reg);
                usage_next      = usage_reg + UNIT_W'(cls_reg);
                out_addr_next   = {unit_reg + HDR_W'(1), 3'b000};
                out_reused_next = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            S_FHDR: begin
                head_raddr = hdr_rdata_reg[CLASS_W-1:0];
                cls_next   = hdr_rdata_reg[CLASS_W-1:0];
                if (|hdr_rdata_reg[HDR_W-1:CLASS_W]) begin
                    out_status_next = ST_BAD_FREE;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    state_next = S_FPUSH;
                end
            end
            S_FPUSH: begin
                hdr_we         = 1'b1;
                hdr_wdata      = head_rdata_reg[HDR_W-1:0];
                head_we        = 1'b1;
                head_wdata     = UNIT_W'(unit_reg) + UNIT_W'(1);
                usage_next     = usage_reg - UNIT_W'(cls_reg);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SCFA_ASSERT(a_pop_delivers, aclk, aresetn, (state_reg == S_APOP) |=> out_valid_reg, "pop without result")
    `SCFA_ASSERT(a_no_overwrite, aclk, aresetn, (out_valid_reg && !m_tready) |-> !s_tready, "ready while result stalled")
    `SCFA_ASSERT(a_clear_blocks, aclk, aresetn, (state_reg == S_CLEAR) |-> !s_tready, "ready during list head clear")
    `SCFA_ASSERT_NEVER(a_bump_bound, aclk, aresetn, bump_reg > UNIT_W'(ARENA_UNITS), "bump pointer beyond arena")
    `SCFA_ASSERT(a_reuse_addr, aclk, aresetn, (out_valid_reg && out_reused_reg) |-> (out_status_reg == ST_OK && out_addr_reg != '0), "reused result without address")

endmodule

`default_nettype wire

### tb/size_class_free_list_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench for size_class_free_list_allocator: alloc and free transfers, each reply
// predicted by an in-bench allocator model and checked field by field.
// Depends on scfla_pkg and the allocator RTL.

module size_class_free_list_allocator_tb
    import scfla_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FREED_KEEP   = 64;
    localparam int PHASE_ITEMS  = 370;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
        logic              reused;
        logic [UNIT_W-1:0] usage;
    } alloc_reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [USER_W-1:0]    m_tuser;

    bit [UNIT_W-1:0] class_heads [NUM_CLASSES];
    bit [HDR_W-1:0]  header_mem  [HDR_DEPTH];
    bit              header_set  [HDR_DEPTH];
    bit [UNIT_W-1:0] bump_ptr;
    bit [UNIT_W-1:0] used_units;

    alloc_reply_t      replies_due [$];
    alloc_reply_t      reply_head;
    logic [ADDR_W-1:0] live_blocks [$];
    logic [ADDR_W-1:0] freed_blocks [$];
    logic [ADDR_W-1:0] corner_addr [4];
    int                send_idle_pct  = 20;
    int                recv_idle_pct  = 48;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    size_class_free_list_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned size_class(input logic [31:0] nbytes);
        return (nbytes >> 3) + 32'(nbytes[2:0] != 3'b000);
    endfunction

    function automatic alloc_reply_t alloc_model(input logic [31:0] nbytes);
        alloc_reply_t r;
        int unsigned  cls;
        int unsigned  unit;
        int unsigned  need;
        int unsigned  page;
        int unsigned  start;
        int unsigned  avail;
        cls = size_class(nbytes);
        r = '{addr: '0, status: ST_OK, reused: 1'b0, usage: '0};
        if (cls >= NUM_CLASSES) begin
            r.status = ST_TOO_LARGE;
        end else if (class_heads[cls] != 0) begin
            unit = (32'(class_heads[cls]) - 1) % HDR_DEPTH;
            class_heads[cls] = UNIT_W'(header_mem[unit]);
            header_mem[unit] = HDR_W'(cls);
            used_units = UNIT_W'(32'(used_units) + cls);
            r.addr = ADDR_W'((unit + 1) * 8);
            r.reused = 1'b1;
        end else begin
            need = cls + 1;
            page = 32'(bump_ptr) / PAGE_UNITS;
            start = 32'(bump_ptr);
            avail = (page < PAGE_COUNT) ? (page + 1) * PAGE_UNITS - 32'(bump_ptr) : 0;
            if (need > avail) begin
                if (page + 1 >= PAGE_COUNT || need > PAGE_UNITS) begin
                    r.status = ST_NO_MEMORY;
                end else begin
                    start = (page + 1) * PAGE_UNITS;
                end
            end
            if (r.status == ST_OK && (start + 1) * 8 > 2 ** ADDR_W - 1) begin
                r.status = ST_NO_MEMORY;
            end
            if (r.status == ST_OK) begin
                header_mem[start % HDR_DEPTH] = HDR_W'(cls);
                header_set[start % HDR_DEPTH] = 1'b1;
                bump_ptr = UNIT_W'(start + need);
                used_units = UNIT_W'(32'(used_units) + cls);
                r.addr = ADDR_W'((start + 1) * 8);
            end
        end
        r.usage = used_units;
        return r;
    endfunction

    function automatic alloc_reply_t free_model(input logic [ADDR_W-1:0] faddr);
        alloc_reply_t r;
        int unsigned  unit;
        int unsigned  cls;
        r = '{addr: '0, status: ST_OK, reused: 1'b0, usage: '0};
        unit = 32'(faddr) / 8 - 1;
        if (faddr != 0) begin
            if (faddr[2:0] != 3'b000 || unit >= bump_ptr || unit >= HDR_DEPTH) begin
                r.status = ST_BAD_FREE;
            end else begin
                cls = 32'(header_mem[unit]);
                if (cls >= NUM_CLASSES) begin
                    r.status = ST_BAD_FREE;
                end else begin
                    header_mem[unit] = HDR_W'(class_heads[cls]);
                    class_heads[cls] = UNIT_W'(unit + 1);
                    used_units = UNIT_W'(32'(used_units) - cls);
                end
            end
        end
        r.usage = used_units;
        return r;
    endfunction

    function automatic bit free_reads_blank(input logic [ADDR_W-1:0] faddr);
        int unsigned unit;
        unit = 32'(faddr) / 8 - 1;
        return faddr != 0 && faddr[2:0] == 3'b000 && unit < bump_ptr && unit < HDR_DEPTH
            && !header_set[unit];
    endfunction

    function automatic bit alloc_reads_blank(input logic [31:0] nbytes);
        int unsigned cls;
        cls = size_class(nbytes);
        return cls < NUM_CLASSES && class_heads[cls] != 0
            && !header_set[(32'(class_heads[cls]) - 1) % HDR_DEPTH];
    endfunction

    function automatic logic [31:0] pick_request_bytes();
        int          sel;
        int unsigned cls;
        sel = $urandom_range(99);
        if (sel < 90) begin
            cls = (sel < 72) ? $urandom_range(48) : $urandom_range(NUM_CLASSES - 1);
            return (cls == 0) ? 32'd0 : cls * 8 - $urandom_range(7);
        end
        if (sel < 96) return $urandom_range(32'hFFFF_FFFF, NUM_CLASSES * 8 - 7);
        return $urandom();
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_item(input op_t op, input logic [31:0] nbytes,
                             input logic [ADDR_W-1:0] faddr, output alloc_reply_t reply);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        reply = (op == OP_ALLOC) ? alloc_model(nbytes) : free_model(faddr);
        replies_due.push_back(reply);
        if (op == OP_ALLOC && reply.status == ST_OK) live_blocks.push_back(reply.addr);
        if (op == OP_FREE && reply.status == ST_OK && faddr != 0) begin
            freed_blocks.push_back(faddr);
            if (freed_blocks.size() > FREED_KEEP) void'(freed_blocks.pop_front());
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({faddr, nbytes});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic test_size_classes();
        alloc_reply_t reply;
        send_item(OP_ALLOC, 32'd0, '0, reply);
        corner_addr[0] = reply.addr;
        send_item(OP_ALLOC, 32'd1, '1, reply);
        corner_addr[1] = reply.addr;
        send_item(OP_ALLOC, NUM_CLASSES * 8 - 8, '0, reply);
        corner_addr[2] = reply.addr;
        send_item(OP_ALLOC, 32'd8, '1, reply);
        corner_addr[3] = reply.addr;
        send_item(OP_ALLOC, NUM_CLASSES * 8 - 7, '0, reply);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, '1, reply);
    endtask

    task automatic test_bad_frees();
        alloc_reply_t reply;
        send_item(OP_FREE, '0, '0, reply);
        send_item(OP_FREE, '1, ADDR_W'(corner_addr[1] + ADDR_W'(4)), reply);
        send_item(OP_FREE, '0, 20'hFFFF8, reply);
        send_item(OP_FREE, '1, 20'hFFFFF, reply);
    endtask

    task automatic test_list_reuse();
        alloc_reply_t reply;
        send_item(OP_FREE, '0, corner_addr[3], reply);
        send_item(OP_FREE, '0, corner_addr[1], reply);
        send_item(OP_FREE, '0, corner_addr[1], reply);
        send_item(OP_ALLOC, 32'd5, '0, reply);
        send_item(OP_FREE, '0, corner_addr[2], reply);
        send_item(OP_ALLOC, NUM_CLASSES * 8 - 15, '0, reply);
        send_item(OP_FREE, '0, corner_addr[2], reply);
        send_item(OP_FREE, '0, corner_addr[0], reply);
        send_item(OP_FREE, '0, corner_addr[0], reply);
        send_item(OP_ALLOC, 32'd0, '0, reply);
        send_item(OP_ALLOC, 32'd0, '0, reply);
    endtask

    task automatic test_random_traffic(input int count);
        alloc_reply_t      reply;
        logic [31:0]       nbytes;
        logic [ADDR_W-1:0] faddr;
        op_t               op;
        int                sel;
        int                idx;
        for (int i = 0; i < count; i++) begin
            sel    = $urandom_range(99);
            nbytes = $urandom();
            faddr  = ADDR_W'($urandom());
            op     = OP_FREE;
            if (sel < 50 || (sel < 88 && live_blocks.size() == 0)) begin
                nbytes = pick_request_bytes();
                if (!alloc_reads_blank(nbytes)) op = OP_ALLOC;
            end else if (sel < 88) begin
                idx   = $urandom_range(live_blocks.size() - 1);
                faddr = live_blocks[idx];
                live_blocks.delete(idx);
            end else begin
                case ($urandom_range(3))
                    0: faddr = '0;
                    1: if (freed_blocks.size() != 0)
                        faddr = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
                    2: faddr[2:0] = 3'b000;
                    default: ;
                endcase
            end
            if (op == OP_FREE && free_reads_blank(faddr)) faddr[0] = 1'b1;
            send_item(op, nbytes, faddr, reply);
        end
    endtask

    task automatic test_arena_exhaustion();
        alloc_reply_t reply;
        int unsigned  room;
        int unsigned  cls;
        int           guard;
        for (guard = 0; guard < 2000 && bump_ptr < ARENA_UNITS - 1; guard++) begin
            room = PAGE_UNITS - 32'(bump_ptr) % PAGE_UNITS;
            cls = (32'(bump_ptr) / PAGE_UNITS < PAGE_COUNT - 1 || room > NUM_CLASSES + 1)
                ? NUM_CLASSES - 1 : room - 2;
            if (alloc_reads_blank(cls * 8)) break;
            send_item(OP_ALLOC, cls * 8, ADDR_W'($urandom()), reply);
        end
        while (class_heads[0] != 0 && !alloc_reads_blank(0) && guard < 4000) begin
            send_item(OP_ALLOC, 32'd0, ADDR_W'($urandom()), reply);
            guard++;
        end
        if (class_heads[0] == 0) send_item(OP_ALLOC, 32'd0, ADDR_W'($urandom()), reply);
        if (!alloc_reads_blank(32'd9)) send_item(OP_ALLOC, 32'd9, ADDR_W'($urandom()), reply);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                reply_head = replies_due.pop_front();
                check_field("block_address", 32'(reply_head.addr), 32'(m_tdata[ADDR_W-1:0]));
                check_field("usage_units", 32'(reply_head.usage),
                            32'(m_tdata[ADDR_W +: UNIT_W]));
                check_field("status", 32'(reply_head.status), 32'(m_tuser[1:0]));
                check_field("reused", 32'(reply_head.reused), 32'(m_tuser[2]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_size_classes();
        test_bad_frees();
        test_list_reuse();
        test_random_traffic(PHASE_ITEMS);
        send_idle_pct = 48;
        recv_idle_pct = 20;
        test_random_traffic(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);
        test_arena_exhaustion();
        test_random_traffic(40);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
